// ===== hdl/acd_pkg.sv =====
// Package for the condition and class decoder.
// Holds condition codes, class codes, the decode rule table and shared types.
// No dependencies.
package acd_pkg;

	// Condition field codes, bits 31:28 of the instruction
	typedef enum logic [3:0] {
		COND_EQ = 4'h0,
		COND_NE = 4'h1,
		COND_CS = 4'h2,
		COND_CC = 4'h3,
		COND_MI = 4'h4,
		COND_PL = 4'h5,
		COND_VS = 4'h6,
		COND_VC = 4'h7,
		COND_HI = 4'h8,
		COND_LS = 4'h9,
		COND_GE = 4'ha,
		COND_LT = 4'hb,
		COND_GT = 4'hc,
		COND_LE = 4'hd,
		COND_AL = 4'he,
		COND_NV = 4'hf
	} cond_t;

	// Instruction class codes
	typedef enum logic [3:0] {
		CLS_NONE    = 4'd0,
		CLS_MUL     = 4'd1,
		CLS_SWP     = 4'd2,
		CLS_DP      = 4'd3,
		CLS_UNDEF   = 4'd4,
		CLS_LDRSTR  = 4'd5,
		CLS_LDMSTM  = 4'd6,
		CLS_B       = 4'd7,
		CLS_CDP     = 4'd8,
		CLS_MRCMCR  = 4'd9,
		CLS_SWI     = 4'd10,
		CLS_BX      = 4'd11,
		CLS_MOVIMM  = 4'd12
	} cls_t;

	localparam int NumRules = 12;

	// Priority chain, first entry has highest priority
	localparam logic [31:0] RULE_MASK [NumRules] = '{
		32'h0fc00090, 32'h0ffffff0, 32'h0fb00ff0, 32'h0fb00000,
		32'h0c000000, 32'h0e000010, 32'h0c000000, 32'h0e000000,
		32'h0e000000, 32'h0f000010, 32'h0f000010, 32'h0f000000
	};

	localparam logic [31:0] RULE_PATTERN [NumRules] = '{
		32'h00000090, 32'h012fff10, 32'h01000090, 32'h03000000,
		32'h00000000, 32'h06000010, 32'h04000000, 32'h08000000,
		32'h0a000000, 32'h0e000000, 32'h0e000010, 32'h0f000000
	};

	localparam cls_t RULE_CLASS [NumRules] = '{
		CLS_MUL, CLS_BX, CLS_SWP, CLS_MOVIMM,
		CLS_DP, CLS_UNDEF, CLS_LDRSTR, CLS_LDMSTM,
		CLS_B, CLS_CDP, CLS_MRCMCR, CLS_SWI
	};

	// Status flags as carried with each item
	typedef struct packed {
		logic v;
		logic c;
		logic z;
		logic n;
	} flags_t;

	// Decode result
	typedef struct packed {
		cls_t instruction_class;
		logic condition_passed;
	} res_t;

endpackage

// ===== hdl/acd_cond.sv =====
// Condition check: evaluates the condition field against N, Z, C, V.
// Depends on acd_pkg.
module acd_cond
	import acd_pkg::*;
(
	input  cond_t  code,
	input  flags_t flags,
	output logic   passed
);

	// Standard condition table; NV never passes
	always_comb begin
		unique case (code)
			COND_EQ: passed = flags.z;
			COND_NE: passed = !flags.z;
			COND_CS: passed = flags.c;
			COND_CC: passed = !flags.c;
			COND_MI: passed = flags.n;
			COND_PL: passed = !flags.n;
			COND_VS: passed = flags.v;
			COND_VC: passed = !flags.v;
			COND_HI: passed = flags.c && !flags.z;
			COND_LS: passed = !flags.c || flags.z;
			COND_GE: passed = (flags.n == flags.v);
			COND_LT: passed = (flags.n != flags.v);
			COND_GT: passed = !flags.z && (flags.n == flags.v);
			COND_LE: passed = flags.z || (flags.n != flags.v);
			COND_AL: passed = 1'b1;
			COND_NV: passed = 1'b0;
			default: passed = 1'b0;
		endcase
	end

endmodule

// ===== hdl/acd_class.sv =====
// Class decode: priority chain of mask-and-compare tests on the word.
// Depends on acd_pkg.
module acd_class
	import acd_pkg::*;
(
	input  logic [31:0] word,
	output cls_t        cls
);

	// Scan from lowest priority up so the first matching rule wins
	always_comb begin
		cls = CLS_NONE;
		for (int i = NumRules - 1; i >= 0; i--) begin
			if ((word & RULE_MASK[i]) == RULE_PATTERN[i]) begin
				cls = RULE_CLASS[i];
			end
		end
	end

endmodule

// ===== hdl/arm_condition_and_class_decoder_unit.sv =====
// Top level of the condition and class decoder: input register, decode, result register.
// Depends on acd_pkg, acd_cond and acd_class.
//
//  channel  | dir | fields (lsb first)
//  ---------+-----+---------------------------------------------------------------
//  s_axis   | in  | instruction_word[31:0], N[32], Z[33], C[34], V[35], zero[39:36]
//  m_axis   | out | condition_passed[0], instruction_class[4:1], zero[7:5]
//
// Two register stages: an accepted item passes from the input register to the result
// register and then leaves on m_axis. One item per cycle sustained while m_axis is ready;
// the only logic between the stages is the condition table, the twelve-rule priority
// chain and the masking of the class on a failed condition.
// arst_n clears both valid bits; payload registers are not reset.
// Back-pressure on m_axis stalls both stages; s_axis_tready drops only when both are full.
module arm_condition_and_class_decoder_unit
	import acd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // instruction_word, N, Z, C, V, zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata    // condition_passed, instruction_class, zero pad
);

	logic        valid_s1;
	logic [31:0] word_s1;
	flags_t      flags_s1;
	logic        valid_s2;
	res_t        res_s2;

	logic   ready_s2;
	logic   ready_s1;
	logic   passed;
	cls_t   cls;
	res_t   res_next;

	// Stage readiness
	assign ready_s2      = !valid_s2 || m_axis_tready;
	assign ready_s1      = !valid_s1 || ready_s2;
	assign s_axis_tready = ready_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && s_axis_tvalid) begin
			word_s1  <= s_axis_tdata[31:0];
			flags_s1 <= '{v: s_axis_tdata[35], c: s_axis_tdata[34],
				z: s_axis_tdata[33], n: s_axis_tdata[32]};
		end
	end

	// Decode
	acd_cond u_cond (
		.code   (cond_t'(word_s1[31:28])),
		.flags  (flags_s1),
		.passed (passed)
	);

	acd_class u_class (
		.word (word_s1),
		.cls  (cls)
	);

	always_comb begin
		res_next.condition_passed  = passed;
		res_next.instruction_class = passed ? cls : CLS_NONE;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			res_s2 <= res_next;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {3'b000, res_s2.instruction_class, res_s2.condition_passed};

	// A failed condition never carries a class
	a_fail_no_class: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.condition_passed |-> res_s2.instruction_class == CLS_NONE)
		else $error("class given for a failed condition");

	// An item moving out of stage 1 lands in the result register
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ready_s2 |=> valid_s2)
		else $error("item lost between stages");

	// The never condition does not pass
	a_nv_fails: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ready_s2 && word_s1[31:28] == COND_NV |=> !res_s2.condition_passed)
		else $error("never condition passed");

	// Class codes stay within the defined set
	a_cls_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> res_s2.instruction_class <= CLS_MOVIMM)
		else $error("class code out of range");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the ARM condition and instruction class decoder.
// Directed table, hand-constrained random words; checked against typed rows or a local model.
// Depends on acd_pkg and arm_condition_and_class_decoder_unit.
module testbench;
	import acd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD   = 10;
	localparam int RANDOM_ITEMS = 1200;
	localparam int TAIL_CYCLES  = 16;

	// Local copy of the decode priority chain, highest priority first
	localparam int DEC_RULES = 12;
	localparam logic [31:0] DEC_MASK [DEC_RULES] = '{
		32'h0fc00090, 32'h0ffffff0, 32'h0fb00ff0, 32'h0fb00000,
		32'h0c000000, 32'h0e000010, 32'h0c000000, 32'h0e000000,
		32'h0e000000, 32'h0f000010, 32'h0f000010, 32'h0f000000
	};
	localparam logic [31:0] DEC_PATTERN [DEC_RULES] = '{
		32'h00000090, 32'h012fff10, 32'h01000090, 32'h03000000,
		32'h00000000, 32'h06000010, 32'h04000000, 32'h08000000,
		32'h0a000000, 32'h0e000000, 32'h0e000010, 32'h0f000000
	};
	localparam cls_t DEC_CLASS [DEC_RULES] = '{
		CLS_MUL, CLS_BX, CLS_SWP, CLS_MOVIMM,
		CLS_DP, CLS_UNDEF, CLS_LDRSTR, CLS_LDMSTM,
		CLS_B, CLS_CDP, CLS_MRCMCR, CLS_SWI
	};

	// One row of directed stimulus; flags are {v, c, z, n}
	typedef struct packed {
		logic [31:0] word;
		flags_t      flags;
		logic        typed;
		res_t        result;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 24;
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		// all zeros: EQ with Z clear fails
		'{32'h00000000, 4'b0000, 1'b1, '{CLS_NONE, 1'b0}},
		// all ones: never condition
		'{32'hffffffff, 4'b1111, 1'b1, '{CLS_NONE, 1'b0}},
		'{32'hefffffff, 4'b0000, 1'b0, '{CLS_NONE, 1'b0}},
		// coprocessor load/store matches nothing
		'{32'hec000000, 4'b0000, 1'b1, '{CLS_NONE, 1'b1}},
		'{32'h00000090, 4'b0010, 1'b0, '{CLS_NONE, 1'b0}},
		'{32'h112fff1e, 4'b0000, 1'b0, '{CLS_NONE, 1'b0}},
		'{32'h21000091, 4'b0100, 1'b0, '{CLS_NONE, 1'b0}},
		// failed conditions give nothing
		'{32'h33000000, 4'b0100, 1'b1, '{CLS_NONE, 1'b0}},
		'{32'h40800001, 4'b0001, 1'b0, '{CLS_NONE, 1'b0}},
		'{32'h56000010, 4'b0001, 1'b1, '{CLS_NONE, 1'b0}},
		'{32'h65900000, 4'b1000, 1'b0, '{CLS_NONE, 1'b0}},
		'{32'h78bd0000, 4'b1000, 1'b1, '{CLS_NONE, 1'b0}},
		'{32'h8a000000, 4'b0100, 1'b0, '{CLS_NONE, 1'b0}},
		'{32'h9e000000, 4'b0100, 1'b1, '{CLS_NONE, 1'b0}},
		'{32'hae100010, 4'b1001, 1'b0, '{CLS_NONE, 1'b0}},
		'{32'hbf000000, 4'b0001, 1'b0, '{CLS_NONE, 1'b0}},
		'{32'hc0000000, 4'b0000, 1'b0, '{CLS_NONE, 1'b0}},
		'{32'hd0000000, 4'b0000, 1'b1, '{CLS_NONE, 1'b0}},
		'{32'he3000000, 4'b0000, 1'b0, '{CLS_NONE, 1'b0}},
		'{32'he7ffffff, 4'b0000, 1'b0, '{CLS_NONE, 1'b0}},
		'{32'hee000000, 4'b0000, 1'b0, '{CLS_NONE, 1'b0}},
		'{32'he8bd4000, 4'b0000, 1'b0, '{CLS_NONE, 1'b0}},
		'{32'hea000000, 4'b0000, 1'b0, '{CLS_NONE, 1'b0}},
		'{32'he12fff10, 4'b1111, 1'b0, '{CLS_NONE, 1'b0}}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;   // instruction_word, N, Z, C, V, zero pad
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // condition_passed, instruction_class, zero pad

	// Typed expectation travelling with the item being driven
	logic        drive_typed = 1'b0;
	res_t        drive_result = '0;

	res_t        pending_decodes [$];
	int          mismatches = 0;
	bit          send_calm = 1'b0;
	bit          sink_calm = 1'b0;

	arm_condition_and_class_decoder_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Condition field against the flags
	function automatic logic condition_holds(input logic [3:0] code, input flags_t f);
		case (cond_t'(code))
			COND_EQ: return f.z;
			COND_NE: return !f.z;
			COND_CS: return f.c;
			COND_CC: return !f.c;
			COND_MI: return f.n;
			COND_PL: return !f.n;
			COND_VS: return f.v;
			COND_VC: return !f.v;
			COND_HI: return f.c && !f.z;
			COND_LS: return !f.c || f.z;
			COND_GE: return f.n == f.v;
			COND_LT: return f.n != f.v;
			COND_GT: return !f.z && (f.n == f.v);
			COND_LE: return f.z || (f.n != f.v);
			COND_AL: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	// Expected decode of one word: condition first, then the first matching rule
	function automatic res_t decode_word(input logic [31:0] w, input flags_t f);
		res_t r;
		r.condition_passed  = condition_holds(w[31:28], f);
		r.instruction_class = CLS_NONE;
		if (r.condition_passed) begin
			for (int i = DEC_RULES - 1; i >= 0; i--) begin
				if ((w & DEC_MASK[i]) == DEC_PATTERN[i]) begin
					r.instruction_class = DEC_CLASS[i];
				end
			end
		end
		return r;
	endfunction

	// Idle cycles before the next item; calm stretches run with none
	function automatic int draw_gap(inout bit calm);
		if ($urandom_range(0, 99) < 4) begin
			calm = !calm;
		end
		return calm ? 0 : int'($urandom_range(0, 15));
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	// Drive one item from a falling edge and return at the falling edge after acceptance
	task automatic push_item(input logic [31:0] w, input flags_t f, input logic typed,
			input res_t result);
		int gap;
		gap = draw_gap(send_calm);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0000, f, w};
		drive_typed   <= typed;
		drive_result  <= result;
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	// Stop sending and wait for every outstanding result
	task automatic hold_until_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_decodes.size() != 0) @(negedge clk);
	endtask

	// Predict on acceptance, compare on each result
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (drive_typed) begin
					pending_decodes.push_back(drive_result);
				end else begin
					pending_decodes.push_back(decode_word(s_axis_tdata[31:0],
						flags_t'(s_axis_tdata[35:32])));
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_decodes.size() == 0) begin
					flag_mismatch("unexpected result, class", int'(m_axis_tdata[4:1]), 0);
				end else begin
					res_t want;
					want = pending_decodes.pop_front();
					if (m_axis_tdata[0] !== want.condition_passed) begin
						flag_mismatch("condition_passed", int'(m_axis_tdata[0]),
							int'(want.condition_passed));
					end
					if (m_axis_tdata[4:1] !== want.instruction_class) begin
						flag_mismatch("instruction_class", int'(m_axis_tdata[4:1]),
							int'(want.instruction_class));
					end
				end
			end
		end
	end

	// Result side: random stalls per item
	initial begin
		int gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = draw_gap(sink_calm);
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			@(negedge clk);
		end
	end

	// Stimulus and end of run
	initial begin
		logic [31:0] w;
		flags_t      f;
		int          pick;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			push_item(DIRECTED[i].word, DIRECTED[i].flags, DIRECTED[i].typed,
				DIRECTED[i].result);
		end
		hold_until_drained();

		// random: mostly words shaped on one rule, some coprocessor transfers, some noise
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pick = $urandom_range(0, 9);
			w = $urandom();
			if (pick < 7) begin
				int idx;
				idx = $urandom_range(0, DEC_RULES - 1);
				w = (w & ~DEC_MASK[idx]) | DEC_PATTERN[idx];
			end else if (pick == 7) begin
				w = (w & ~32'h0e000000) | 32'h0c000000;
			end
			if ($urandom_range(0, 3) == 0) begin
				w[31:28] = COND_AL;
			end
			f = flags_t'(4'($urandom_range(0, 15)));
			if (i == RANDOM_ITEMS / 2) begin
				hold_until_drained();
			end
			push_item(w, f, 1'b0, '0);
		end

		hold_until_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0) begin
			$display("arm_condition_and_class_decoder_unit regression: pass");
		end else begin
			$display("arm_condition_and_class_decoder_unit regression: fail");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5ms;
		$display("arm_condition_and_class_decoder_unit regression: fail");
		$finish;
	end

endmodule

// ===== arm_condition_and_class_decoder_unit.f =====
hdl/acd_pkg.sv
hdl/acd_cond.sv
hdl/acd_class.sv
hdl/arm_condition_and_class_decoder_unit.sv
tb/testbench.sv
